// ----- rtl/core/wmat_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted moving average trend package
// Shared constants, trend codes, controller states and command/status types.
// ----------------------------------------------------------------------------
`default_nettype none

package wmat_pkg;

  localparam int MAX_WINDOW_DEF  = 8;
  localparam int SAMPLE_BITS_DEF = 10;
  localparam int CFG_BITS        = 4;
  localparam int FRAC_BITS       = 8;
  localparam int WIN_LIMIT       = 15;

  localparam logic [CFG_BITS-1:0] WINDOW_RESET = 4'd5;

  typedef enum logic [1:0] {
    TREND_NONE = 2'd0,
    TREND_IDLE = 2'd1,
    TREND_DOWN = 2'd2,
    TREND_UP   = 2'd3
  } trend_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_DIV_START,
    ST_DIV
  } state_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic div_start;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_tap;
    logic div_done;
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

// ----- rtl/core/wmat_if.sv -----
// ----------------------------------------------------------------------------
// Weighted moving average trend channels
// Sample, result and window configuration channels with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface wmat_sample_if #(
  parameter int SAMPLE_BITS = wmat_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface wmat_result_if #(
  parameter int SAMPLE_BITS = wmat_pkg::SAMPLE_BITS_DEF
);
  logic                                        valid;
  logic                                        ready;
  logic        [SAMPLE_BITS+wmat_pkg::FRAC_BITS-1:0] average_fixed;
  logic signed [SAMPLE_BITS:0]                 deviation;
  logic        [1:0]                           trend;

  modport source (output valid, output average_fixed, output deviation, output trend,
                  input ready);
  modport sink   (input valid, input average_fixed, input deviation, input trend,
                  output ready);
endinterface

interface wmat_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [wmat_pkg::CFG_BITS-1:0] window_size;

  modport source (output valid, output window_size, input ready);
  modport sink   (input valid, input window_size, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/wmat_div.sv -----
// ----------------------------------------------------------------------------
// Weighted moving average trend divider
// Restoring divider, one quotient bit per cycle, with a remainder flag.
// ----------------------------------------------------------------------------
`default_nettype none

module wmat_div #(
  parameter int DIVIDEND_BITS = 24,
  parameter int DIVISOR_BITS  = 6
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     start,
  input  wire logic [DIVIDEND_BITS-1:0] dividend,
  input  wire logic [DIVISOR_BITS-1:0]  divisor,
  output logic                          done,
  output logic [DIVIDEND_BITS-1:0]      quotient,
  output logic                          rem_nz
);

  localparam int RB = DIVISOR_BITS + 1;
  localparam int CB = $clog2(DIVIDEND_BITS + 1);

  logic              running;
  logic [CB-1:0]     count;
  logic [RB-1:0]     rem;
  logic [DIVISOR_BITS-1:0] dsr;
  logic [RB-1:0]     shifted;
  logic [RB:0]       diff;

  always_comb begin
    shifted = {rem[RB-2:0], quotient[DIVIDEND_BITS-1]};
    diff    = {1'b0, shifted} - {2'b00, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= '0;
    end else if (start) begin
      running <= 1'b1;
      done    <= 1'b0;
      count   <= CB'(DIVIDEND_BITS);
    end else if (running) begin
      count <= count - 1'b1;
      if (count == CB'(1)) begin
        running <= 1'b0;
        done    <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dsr      <= divisor;
    end else if (running) begin
      quotient <= {quotient[DIVIDEND_BITS-2:0], ~diff[RB]};
      rem      <= diff[RB] ? shifted : diff[RB-1:0];
    end
  end

  assign rem_nz = |rem;

endmodule

`default_nettype wire

// ----- rtl/core/wmat_dp.sv -----
// ----------------------------------------------------------------------------
// Weighted moving average trend datapath
// Sample ring, serial weighted sum, divider and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wmat_dp #(
  parameter int MAX_WINDOW  = wmat_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = wmat_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_valid,
  input  wire logic [wmat_pkg::CFG_BITS-1:0]          cfg_data,
  input  wire logic [SAMPLE_BITS-1:0]                 sample,
  input  wire wmat_pkg::ctrl_cmd_t                    cmd,
  output wmat_pkg::dp_status_t                        status,
  input  wire logic                                   out_ready,
  output logic                                        out_valid,
  output logic [SAMPLE_BITS+wmat_pkg::FRAC_BITS-1:0]  average_fixed,
  output logic signed [SAMPLE_BITS:0]                 deviation,
  output logic [1:0]                                  trend
);

  import wmat_pkg::*;

  localparam int AW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int FB   = $clog2(MAX_WINDOW + 1);
  localparam int NMAX = (MAX_WINDOW < WIN_LIMIT) ? MAX_WINDOW : WIN_LIMIT;
  localparam int NB   = $clog2(NMAX + 1);
  localparam int WMAX = NMAX * (NMAX + 1) / 2;
  localparam int WB   = $clog2(WMAX + 1);
  localparam int SB   = SAMPLE_BITS + WB;
  localparam int QB   = SB + FRAC_BITS;
  localparam int CB   = (FB > CFG_BITS) ? FB : CFG_BITS;

  logic [CFG_BITS-1:0]    window_size;
  logic [AW-1:0]          write_slot;
  logic [FB-1:0]          fill;
  logic                   issue_d;

  logic [SAMPLE_BITS-1:0] history [MAX_WINDOW];
  logic [SAMPLE_BITS-1:0] rd_data;
  logic [AW-1:0]          rd_ptr;
  logic [SAMPLE_BITS-1:0] s_reg;
  logic                   first;
  logic [NB-1:0]          weight;
  logic [NB-1:0]          wd;
  logic [SB-1:0]          sum;
  logic [WB-1:0]          total;

  logic [FB-1:0]          fill_next;
  logic [CB-1:0]          eff;
  logic [CB-1:0]          n_sel;
  logic [NB-1:0]          n_next;
  logic [NB:0]            n_plus;
  logic [2*NB:0]          w_prod;
  logic [SAMPLE_BITS+NB-1:0] prod;

  logic                   div_done;
  logic [QB-1:0]          quotient;
  logic                   rem_nz;
  logic [SAMPLE_BITS-1:0] q_int;
  logic                   frac_nz;
  logic                   above;
  logic [SAMPLE_BITS+1:0] dev_w;
  trend_t                 trend_next;

  always_comb begin
    fill_next = (fill == FB'(MAX_WINDOW)) ? fill : fill + 1'b1;
    if (window_size == '0) begin
      eff = CB'(1);
    end else if (CB'(window_size) > CB'(MAX_WINDOW)) begin
      eff = CB'(MAX_WINDOW);
    end else begin
      eff = CB'(window_size);
    end
    n_sel  = (eff < CB'(fill_next)) ? eff : CB'(fill_next);
    n_next = n_sel[NB-1:0];
    n_plus = {1'b0, n_next} + 1'b1;
    w_prod = (2*NB+1)'(n_next) * (2*NB+1)'(n_plus);
    prod   = rd_data * wd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_RESET;
      write_slot  <= '0;
      fill        <= '0;
      issue_d     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_valid) begin
        window_size <= cfg_data;
      end
      if (cmd.start) begin
        write_slot <= (write_slot == AW'(MAX_WINDOW - 1)) ? '0 : write_slot + 1'b1;
        fill       <= fill_next;
      end
      issue_d <= cmd.issue;
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      history[write_slot] <= sample;
    end
    rd_data <= history[rd_ptr];
  end

  always_ff @(posedge clk) begin
    wd <= weight;
    if (cmd.start) begin
      s_reg  <= sample;
      first  <= (fill == '0);
      rd_ptr <= write_slot;
      weight <= n_next;
      total  <= w_prod[WB:1];
      sum    <= '0;
    end else begin
      if (cmd.issue) begin
        rd_ptr <= (rd_ptr == '0) ? AW'(MAX_WINDOW - 1) : rd_ptr - 1'b1;
        weight <= weight - 1'b1;
      end
      if (issue_d) begin
        sum <= sum + SB'(prod);
      end
    end
  end

  wmat_div #(
    .DIVIDEND_BITS (QB),
    .DIVISOR_BITS  (WB)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend ({sum, FRAC_BITS'(0)}),
    .divisor  (total),
    .done     (div_done),
    .quotient (quotient),
    .rem_nz   (rem_nz)
  );

  // The integer part of the average is rounded up for a positive deviation.
  always_comb begin
    q_int   = quotient[FRAC_BITS +: SAMPLE_BITS];
    frac_nz = (|quotient[FRAC_BITS-1:0]) | rem_nz;
    above   = s_reg > q_int;
    dev_w   = {2'b00, s_reg} - {2'b00, q_int} - (SAMPLE_BITS+2)'(above & frac_nz);
    if (first) begin
      trend_next = TREND_NONE;
    end else if (dev_w == '0) begin
      trend_next = TREND_IDLE;
    end else if (dev_w[SAMPLE_BITS+1]) begin
      trend_next = TREND_DOWN;
    end else begin
      trend_next = TREND_UP;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      average_fixed <= quotient[SAMPLE_BITS+FRAC_BITS-1:0];
      deviation     <= dev_w[SAMPLE_BITS:0];
      trend         <= trend_next;
    end
  end

  always_comb begin
    status.last_tap = (weight == NB'(1));
    status.div_done = div_done;
    status.out_busy = out_valid & ~out_ready;
  end

endmodule

`default_nettype wire

// ----- rtl/core/wmat_ctrl.sv -----
// ----------------------------------------------------------------------------
// Weighted moving average trend controller
// Sequences sample capture, the weighted sum, the division and the result.
// ----------------------------------------------------------------------------
`default_nettype none

module wmat_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire wmat_pkg::dp_status_t status,
  output wmat_pkg::ctrl_cmd_t       cmd
);

  import wmat_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_MAC;
        end
      end
      ST_MAC: begin
        if (status.last_tap) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_next = ST_DIV_START;
      end
      ST_DIV_START: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done && !status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd.start     = 1'b0;
    cmd.issue     = 1'b0;
    cmd.div_start = 1'b0;
    cmd.load_out  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_MAC: begin
        cmd.issue = 1'b1;
      end
      ST_DRAIN: begin
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
      end
      ST_DIV: begin
        cmd.load_out = status.div_done & ~status.out_busy;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/weighted_moving_average_trend.sv -----
// Each accepted beat runs the serial weighted sum over its n taps, where n is the
// number of averaged samples, then the divider; Q = SAMPLE_BITS + clog2(Wmax + 1)
// + 8 is the quotient width of the one-bit-per-cycle divider (Q = 24 at the defaults).
// One sample is worked on at a time, over the ring memory port and the divider; a
// waiting result does not block the next sample, but holds the next result back.
// Reset clears the ring pointer, fill count and handshakes; window_size is 5.
// ----------------------------------------------------------------------------
// Weighted moving average trend
// Linearly weighted moving average of a sample stream with a trend code.
// ----------------------------------------------------------------------------
`default_nettype none

module weighted_moving_average_trend #(
  parameter int MAX_WINDOW  = wmat_pkg::MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = wmat_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  wmat_cfg_if.sink      cfg,
  wmat_sample_if.sink   samples,
  wmat_result_if.source results
);

  import wmat_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       in_ready;

  assign cfg.ready     = 1'b1;
  assign samples.ready = in_ready;

  wmat_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wmat_dp #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg.valid),
    .cfg_data      (cfg.window_size),
    .sample        (samples.sample),
    .cmd           (cmd),
    .status        (status),
    .out_ready     (results.ready),
    .out_valid     (results.valid),
    .average_fixed (results.average_fixed),
    .deviation     (results.deviation),
    .trend         (results.trend)
  );

`ifndef NO_ASSERTIONS
  assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> !samples.ready)
    else $error("sample beat accepted while a sample is still in work");

  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> (!results.valid || results.ready))
    else $error("result register overwritten before its beat was taken");

  assert property (@(posedge clk) disable iff (rst)
    cmd.div_start |=> !status.div_done)
    else $error("divider reports done right after a start");

  assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.trend == TREND_NONE) |-> (results.deviation == '0))
    else $error("first sample result carries a nonzero deviation");
`endif

endmodule

`default_nettype wire

// ----- test/wmat_trend_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weighted moving average trend checker
// Watches the configuration, sample and result channels. It keeps its own
// sample ring and window setting, works out the average, deviation and trend
// for every accepted sample beat, and compares each result beat in order.
// ----------------------------------------------------------------------------

module wmat_trend_checker (
  input  logic   clk,
  input  logic   rst,
  wmat_cfg_if    cfg,
  wmat_sample_if samples,
  wmat_result_if results,
  output int     mismatches,
  output int     outstanding
);

  import wmat_pkg::*;

  localparam int RING_DEPTH = MAX_WINDOW_DEF;
  localparam int SBITS      = SAMPLE_BITS_DEF;
  localparam int ABITS      = SAMPLE_BITS_DEF + FRAC_BITS;

  typedef struct packed {
    logic [ABITS-1:0]  average_fixed;
    logic signed [SBITS:0] deviation;
    trend_t            trend;
  } trend_result_t;

  logic [SBITS-1:0]    ring [RING_DEPTH];
  logic [2:0]          wr_slot;
  int                  fill_cnt;
  logic [CFG_BITS-1:0] win_reg;
  trend_result_t       pending_results [$];
  trend_result_t       want;
  trend_result_t       got;

  task automatic predict_trend(input logic [SBITS-1:0] s, output trend_result_t r);
    int         n;
    int         sum;
    int         weights;
    int         num;
    int         dev;
    bit         first;
    logic [2:0] slot;
    first = (fill_cnt == 0);
    ring[wr_slot] = s;
    wr_slot = wr_slot + 3'd1;
    if (fill_cnt < RING_DEPTH) fill_cnt++;
    if (win_reg == 0) n = 1;
    else if (win_reg > RING_DEPTH) n = RING_DEPTH;
    else n = int'(win_reg);
    if (n > fill_cnt) n = fill_cnt;
    sum = 0;
    for (int k = 0; k < n; k++) begin
      slot = 3'(int'(wr_slot) - 1 - k);
      sum += int'(ring[slot]) * (n - k);
    end
    weights = n * (n + 1) / 2;
    num = int'(s) * weights - sum;
    dev = num / weights;
    r.average_fixed = ABITS'((sum << FRAC_BITS) / weights);
    r.deviation = (SBITS + 1)'(dev);
    if (first) r.trend = TREND_NONE;
    else if (dev == 0) r.trend = TREND_IDLE;
    else if (dev < 0) r.trend = TREND_DOWN;
    else r.trend = TREND_UP;
  endtask

  initial begin
    mismatches = 0;
    outstanding = 0;
    wr_slot = '0;
    fill_cnt = 0;
    win_reg = WINDOW_RESET;
  end

  always @(posedge clk) begin
    if (rst) begin
      wr_slot = '0;
      fill_cnt = 0;
      win_reg = WINDOW_RESET;
      pending_results.delete();
    end else begin
      if (cfg.valid && cfg.ready) win_reg = cfg.window_size;
      if (samples.valid && samples.ready) begin
        predict_trend(samples.sample, want);
        pending_results.insert(pending_results.size(), want);
      end
      if (results.valid && results.ready) begin
        if (pending_results.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result beat with nothing expected: avg=%0d dev=%0d trend=%0d",
                     $realtime, results.average_fixed, results.deviation, results.trend);
          mismatches++;
        end else begin
          got = pending_results.pop_front();
          if (results.average_fixed !== got.average_fixed ||
              results.deviation !== got.deviation ||
              results.trend !== got.trend) begin
            if (mismatches < 10)
              $display("%0t: expected avg=%0d dev=%0d trend=%0d, got avg=%0d dev=%0d trend=%0d",
                       $realtime, got.average_fixed, got.deviation, got.trend,
                       results.average_fixed, results.deviation, results.trend);
            mismatches++;
          end
        end
      end
    end
    outstanding = pending_results.size();
  end

endmodule

// ----- test/weighted_moving_average_trend_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Weighted moving average trend testbench
// Drives directed and random altitude samples through the block under four
// idling patterns and a range of window settings, including one long result
// hold-off that backs the block up, and reports the checker's verdict.
// ----------------------------------------------------------------------------

module weighted_moving_average_trend_tb;

  import wmat_pkg::*;

  localparam int SBITS = SAMPLE_BITS_DEF;
  localparam logic [SBITS-1:0] SAMPLE_MAX = '1;

  logic clk;
  logic rst;
  int   src_idle_pct;
  int   snk_stall_pct;
  int   hold_cycles;
  int   mismatches;
  int   outstanding;
  logic [SBITS-1:0] walk;

  wmat_cfg_if    cfg_ch ();
  wmat_sample_if samp_ch ();
  wmat_result_if res_ch ();

  weighted_moving_average_trend uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .samples (samp_ch),
    .results (res_ch)
  );

  wmat_trend_checker chk (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg_ch),
    .samples     (samp_ch),
    .results     (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("** weighted_moving_average_trend: FAILED **");
    $finish;
  end

  // The result side stalls at random, or holds off for a counted stretch.
  initial begin
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rst) begin
        res_ch.ready <= 1'b0;
      end else if (hold_cycles > 0) begin
        res_ch.ready <= 1'b0;
        hold_cycles--;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  task automatic send_sample(input logic [SBITS-1:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      samp_ch.valid = 1'b0;
      @(negedge clk);
    end
    samp_ch.valid = 1'b1;
    samp_ch.sample = v;
    @(posedge clk);
    while (!samp_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_window(input logic [CFG_BITS-1:0] w);
    samp_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.window_size = w;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [SBITS-1:0] pick_sample();
    int mode;
    mode = $urandom_range(9);
    if (mode <= 3) begin
      walk = SBITS'($urandom);
    end else if (mode <= 5) begin
      walk = $urandom_range(1) ? SAMPLE_MAX : '0;
    end else if (mode <= 8) begin
      walk = walk + SBITS'($urandom_range(8)) - SBITS'(4);
    end
    return walk;
  endfunction

  initial begin
    rst = 1'b1;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_cycles = 0;
    walk = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.window_size = '0;
    samp_ch.valid = 1'b0;
    samp_ch.sample = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset window of five, starting with the first sample after reset.
    send_sample(SAMPLE_MAX);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    send_sample('0);
    send_sample(10'd512);
    send_sample(10'd512);
    send_sample(10'd512);
    send_sample(10'd512);
    send_sample(10'd512);
    send_sample(10'd512);
    // A window of zero acts as one, and a window above the maximum as eight.
    write_window(4'd0);
    send_sample(10'd1);
    send_sample(SAMPLE_MAX);
    write_window(4'd15);
    send_sample('0);
    send_sample(SAMPLE_MAX);
    send_sample(10'd341);
    write_window(4'd8);
    send_sample(SAMPLE_MAX);
    send_sample(10'd682);
    write_window(4'd1);
    send_sample('0);
    send_sample(10'd7);
    write_window(4'd9);
    send_sample(SAMPLE_MAX);
    send_sample('0);
    write_window(4'd2);
    send_sample(10'd3);
    send_sample(10'd4);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 64; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 64; end
        default: begin src_idle_pct = 9; snk_stall_pct = 9; end
      endcase
      for (int sub = 0; sub < 4; sub++) begin
        case (sub)
          1: write_window((phase % 2) ? 4'd0 : 4'd1);
          2: write_window((phase % 2) ? 4'd15 : 4'd8);
          default: write_window(CFG_BITS'($urandom_range(15)));
        endcase
        if (phase == 0 && sub == 1) hold_cycles = 400;
        for (int i = 0; i < 50; i++) send_sample(pick_sample());
      end
    end

    samp_ch.valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("** weighted_moving_average_trend: PASSED **");
    end else begin
      $display("** weighted_moving_average_trend: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/wmat_pkg.sv
rtl/core/wmat_if.sv
rtl/core/wmat_div.sv
rtl/core/wmat_dp.sv
rtl/core/wmat_ctrl.sv
rtl/core/weighted_moving_average_trend.sv
test/wmat_trend_checker.sv
test/weighted_moving_average_trend_tb.sv
